### src/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types and codes for the first-come reader-writer lock arbiter.
// ----------------------------------------------------------------------------
package frwl_pkg;

  localparam int PACK_SLOTS  = 16;
  localparam int MAX_WAITERS = 255;

  localparam logic [2:0] MODE_READ_WAIT  = 3'd0;
  localparam logic [2:0] MODE_READ_TRY   = 3'd1;
  localparam logic [2:0] MODE_WRITE_WAIT = 3'd2;
  localparam logic [2:0] MODE_WRITE_TRY  = 3'd3;
  localparam logic [2:0] MODE_RELEASE    = 3'd4;
  localparam logic [2:0] MODE_CANCEL     = 3'd5;

  localparam logic [2:0] ST_GRANTED    = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_BUSY       = 3'd2;
  localparam logic [2:0] ST_CLOSED     = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_NOT_HELD   = 3'd5;
  localparam logic [2:0] ST_CANCELLED  = 3'd6;
  localparam logic [2:0] ST_BAD_TICKET = 3'd7;

  localparam logic [1:0] LOCK_FREE    = 2'd0;
  localparam logic [1:0] LOCK_WRITER  = 2'd1;
  localparam logic [1:0] LOCK_READERS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_EXEC,
    S_GDROP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic drop;      // pop head if empty
    logic exec;      // perform request
    logic gdrop;     // grant and drop around it
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_empty;     // live head pack has no waiters
    logic need_drop;      // request needs a head drop first
    logic grant_pending;  // release still has to grant from the ring
    logic grant_open;     // head drops allowed around the grant
  } sts_t;

endpackage

### src/frwl_datapath.sv
// ----------------------------------------------------------------------------
// frwl_datapath
// Lock state, pack ring and result registers of the arbiter.
// ----------------------------------------------------------------------------
module frwl_datapath import frwl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       closed,
  input  logic [2:0] mode,
  input  logic [3:0] ticket,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic [2:0] status,
  output logic [3:0] queued_slot,
  output logic [1:0] lock_mode,
  output logic       grant_valid,
  output logic       grant_is_writer,
  output logic [3:0] grant_slot,
  output logic [7:0] grant_count,
  output logic [7:0] readers_holding
);

  localparam int SW = (PACK_SLOTS > 1) ? $clog2(PACK_SLOTS) : 1;
  localparam int FW = $clog2(PACK_SLOTS + 1);
  localparam int CW = $clog2(MAX_WAITERS + 1);

  logic [1:0]    lock_state;
  logic [CW-1:0] reader_count;
  logic          pack_is_writer     [PACK_SLOTS];
  logic [CW-1:0] pack_waiters       [PACK_SLOTS];
  logic          pack_first_granted [PACK_SLOTS];
  logic [SW-1:0] ring_head, ring_tail;
  logic [FW-1:0] ring_fill;
  logic [2:0]    req_mode;
  logic [3:0]    req_ticket;
  logic          do_grant;

  logic [SW-1:0] head_next, tail_next, last;
  logic          tail_match;

  function automatic logic [SW-1:0] incr(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(PACK_SLOTS - 1)) r = '0;
    else r = s + 1'b1;
    return r;
  endfunction

  always_comb begin
    head_next = incr(ring_head);
    tail_next = incr(ring_tail);
    last = (ring_tail == '0) ? SW'(PACK_SLOTS - 1) : ring_tail - 1'b1;
    sts.head_empty    = (ring_fill != '0) && (pack_waiters[ring_head] == '0);
    sts.need_drop     = !closed &&
                        (req_mode == MODE_READ_WAIT || req_mode == MODE_READ_TRY);
    sts.grant_pending = do_grant && (ring_fill != '0);
    sts.grant_open    = do_grant || grant_valid;
    tail_match = 1'b0;
    if (req_mode == MODE_WRITE_WAIT)
      tail_match = pack_is_writer[last] && !pack_first_granted[last];
    else
      tail_match = !pack_is_writer[last];
  end

  logic [SW:0] off;
  logic        tick_ok;
  always_comb begin
    tick_ok = ({28'd0, req_ticket} < 32'(PACK_SLOTS));
    off = {1'b0, req_ticket[SW-1:0]} + (SW+1)'(PACK_SLOTS) - {1'b0, ring_head};
    if (off >= (SW+1)'(PACK_SLOTS)) off = off - (SW+1)'(PACK_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_state   <= LOCK_FREE;
      reader_count <= '0;
      ring_head    <= '0;
      ring_tail    <= '0;
      ring_fill    <= '0;
      do_grant     <= 1'b0;
      grant_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        req_mode        <= mode;
        req_ticket      <= ticket;
        status          <= ST_BAD_TICKET;
        queued_slot     <= '0;
        grant_valid     <= 1'b0;
        grant_is_writer <= 1'b0;
        grant_slot      <= '0;
        grant_count     <= '0;
        do_grant        <= 1'b0;
      end
      if (cmd.drop && sts.head_empty) begin
        ring_head <= head_next;
        ring_fill <= ring_fill - 1'b1;
      end
      if (cmd.gdrop) begin
        if (sts.head_empty && sts.grant_open) begin
          ring_head <= head_next;
          ring_fill <= ring_fill - 1'b1;
        end else if (sts.grant_pending) begin
          // grant from live head
          do_grant    <= 1'b0;
          grant_valid <= 1'b1;
          grant_slot  <= 4'(ring_head);
          if (pack_is_writer[ring_head]) begin
            pack_waiters[ring_head]       <= pack_waiters[ring_head] - 1'b1;
            pack_first_granted[ring_head] <= 1'b1;
            lock_state      <= LOCK_WRITER;
            grant_is_writer <= 1'b1;
            grant_count     <= 8'd1;
            if (pack_waiters[ring_head] == CW'(1)) begin
              ring_head <= head_next;
              ring_fill <= ring_fill - 1'b1;
            end
          end else begin
            lock_state   <= LOCK_READERS;
            reader_count <= pack_waiters[ring_head];
            grant_count  <= 8'(pack_waiters[ring_head]);
            ring_head    <= head_next;
            ring_fill    <= ring_fill - 1'b1;
          end
        end
      end
      if (cmd.exec) begin
        unique case (req_mode)
          MODE_READ_WAIT, MODE_READ_TRY: begin
            if (closed) status <= ST_CLOSED;
            else if (lock_state != LOCK_WRITER && ring_fill == '0) begin
              if (reader_count >= CW'(MAX_WAITERS)) status <= ST_BUSY;
              else begin
                reader_count <= reader_count + 1'b1;
                lock_state   <= LOCK_READERS;
                status       <= ST_GRANTED;
              end
            end else if (req_mode == MODE_READ_TRY) status <= ST_BUSY;
            else if (ring_fill != '0 && tail_match) begin
              if (pack_waiters[last] >= CW'(MAX_WAITERS)) status <= ST_FULL;
              else begin
                pack_waiters[last] <= pack_waiters[last] + 1'b1;
                status <= ST_QUEUED;
                queued_slot <= 4'(last);
              end
            end else if (ring_fill >= FW'(PACK_SLOTS)) status <= ST_FULL;
            else begin
              pack_is_writer[ring_tail]     <= 1'b0;
              pack_waiters[ring_tail]       <= CW'(1);
              pack_first_granted[ring_tail] <= 1'b0;
              ring_tail   <= tail_next;
              ring_fill   <= ring_fill + 1'b1;
              status      <= ST_QUEUED;
              queued_slot <= 4'(ring_tail);
            end
          end
          MODE_WRITE_WAIT, MODE_WRITE_TRY: begin
            if (closed) status <= ST_CLOSED;
            else if (lock_state == LOCK_FREE) begin
              lock_state <= LOCK_WRITER;
              status     <= ST_GRANTED;
            end else if (req_mode == MODE_WRITE_TRY) status <= ST_BUSY;
            else if (ring_fill != '0 && tail_match) begin
              if (pack_waiters[last] >= CW'(MAX_WAITERS)) status <= ST_FULL;
              else begin
                pack_waiters[last] <= pack_waiters[last] + 1'b1;
                status <= ST_QUEUED;
                queued_slot <= 4'(last);
              end
            end else if (ring_fill >= FW'(PACK_SLOTS)) status <= ST_FULL;
            else begin
              pack_is_writer[ring_tail]     <= 1'b1;
              pack_waiters[ring_tail]       <= CW'(1);
              pack_first_granted[ring_tail] <= 1'b0;
              ring_tail   <= tail_next;
              ring_fill   <= ring_fill + 1'b1;
              status      <= ST_QUEUED;
              queued_slot <= 4'(ring_tail);
            end
          end
          MODE_RELEASE: begin
            if (lock_state == LOCK_WRITER) begin
              lock_state <= LOCK_FREE;
              status     <= ST_GRANTED;
              do_grant   <= 1'b1;
            end else if (reader_count != '0) begin
              reader_count <= reader_count - 1'b1;
              status       <= ST_GRANTED;
              if (reader_count == CW'(1)) begin
                lock_state <= LOCK_FREE;
                do_grant   <= 1'b1;
              end
            end else status <= ST_NOT_HELD;
          end
          MODE_CANCEL: begin
            if (tick_ok && (FW'(off) < ring_fill) &&
                pack_waiters[req_ticket[SW-1:0]] != '0) begin
              pack_waiters[req_ticket[SW-1:0]] <=
                pack_waiters[req_ticket[SW-1:0]] - 1'b1;
              status <= ST_CANCELLED;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign lock_mode       = lock_state;
  assign readers_holding = 8'(reader_count);

endmodule

### src/frwl_ctrl.sv
// ----------------------------------------------------------------------------
// frwl_ctrl
// Sequencer: capture, head drop, execute, grant with drops, result.
// ----------------------------------------------------------------------------
module frwl_ctrl import frwl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_DROP;
      S_DROP:  if (!(sts.need_drop && sts.head_empty)) state_next = S_EXEC;
      S_EXEC:  state_next = S_GDROP;
      S_GDROP: begin
        if (!sts.grant_pending && !(sts.grant_open && sts.head_empty))
          state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_IDLE:  cmd.load = start;
      S_DROP:  cmd.drop = sts.need_drop;
      S_EXEC:  cmd.exec = 1'b1;
      S_GDROP: cmd.gdrop = 1'b1;
      S_DONE:  done = 1'b1;
      default: ;
    endcase
  end

endmodule

### src/fifo_reader_writer_lock_arbiter_core.sv
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock_arbiter_core
// First-come reader-writer lock arbiter with a ring of waiter packs.
//
//   channel   ports                          handshake
//   request   mode, ticket                   start & !busy
//   result    status .. readers_holding      done (one cycle)
//   config    closed_data                    closed_valid & closed_ready
//
// Busy covers the drop, execute, grant and done states, and lasts longer for
// each emptied head pack dropped and when a release grants from the ring; done
// is high in the last of them and the next request is taken in the cycle after.
// Reset is synchronous and empties the ring and frees the lock.
// The result is shown for one cycle with done; it cannot be stalled.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock_arbiter_core import frwl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [3:0] ticket,
  input  logic       closed_valid,
  output logic       closed_ready,
  input  logic       closed_data,
  output logic       done,
  output logic [2:0] status,
  output logic [3:0] queued_slot,
  output logic [1:0] lock_mode,
  output logic       grant_valid,
  output logic       grant_is_writer,
  output logic [3:0] grant_slot,
  output logic [7:0] grant_count,
  output logic [7:0] readers_holding
);

  cmd_t cmd;
  sts_t sts;
  logic closed;

  always_ff @(posedge clk) begin
    if (rst) closed <= 1'b0;
    else if (closed_valid && closed_ready) closed <= closed_data;
  end
  assign closed_ready = !busy;

  frwl_ctrl u_ctrl (
    .clk, .rst, .start, .sts, .cmd, .busy, .done
  );

  frwl_datapath u_dp (
    .clk, .rst, .closed, .mode, .ticket, .cmd, .sts,
    .status, .queued_slot, .lock_mode, .grant_valid, .grant_is_writer,
    .grant_slot, .grant_count, .readers_holding
  );

`ifndef NO_ASSERTIONS
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done while idle");
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    done && lock_mode == LOCK_FREE |-> readers_holding == 8'd0)
    else $error("readers while free");
`endif

endmodule

### verif/fifo_reader_writer_lock_arbiter_core_tb.sv
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock_arbiter_core_tb
// Drives lock requests, predicts each result with a local model of the
// lock and waiter ring, and checks every result field by field.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock_arbiter_core_tb;
  import frwl_pkg::*;

  localparam int SLOTS = 16;
  localparam int WMAX = 255;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] queued_slot;
    logic [1:0] lock_mode;
    logic       grant_valid;
    logic       grant_is_writer;
    logic [3:0] grant_slot;
    logic [7:0] grant_count;
    logic [7:0] readers_holding;
  } lock_result_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] mode = 0;
  logic [3:0] ticket = 0;
  logic closed_valid = 0;
  logic closed_data = 0;
  logic busy, closed_ready, done;
  logic [2:0] status;
  logic [3:0] queued_slot;
  logic [1:0] lock_mode;
  logic grant_valid, grant_is_writer;
  logic [3:0] grant_slot;
  logic [7:0] grant_count, readers_holding;

  fifo_reader_writer_lock_arbiter_core dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // lock model state
  bit m_closed;
  logic [1:0] m_lock;
  int m_readers;
  bit m_is_wr[SLOTS];
  int m_wait[SLOTS];
  bit m_first[SLOTS];
  int m_head, m_tail, m_fill;
  lock_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
  endtask

  function automatic void drop_empty();
    while (m_fill > 0 && m_wait[m_head] == 0) begin
      m_head = (m_head + 1) % SLOTS;
      m_fill--;
    end
  endfunction

  function automatic void pop_head();
    if (m_fill > 0) begin
      m_head = (m_head + 1) % SLOTS;
      m_fill--;
    end
  endfunction

  function automatic void grant_head(ref lock_result_t r);
    int h;
    drop_empty();
    if (m_fill == 0) return;
    h = m_head;
    r.grant_valid = 1;
    r.grant_slot = h;
    if (m_is_wr[h]) begin
      m_wait[h]--;
      m_first[h] = 1;
      m_lock = LOCK_WRITER;
      r.grant_is_writer = 1;
      r.grant_count = 1;
      if (m_wait[h] == 0) pop_head();
    end else begin
      m_lock = LOCK_READERS;
      m_readers = m_wait[h];
      r.grant_count = m_wait[h];
      pop_head();
    end
    drop_empty();
  endfunction

  function automatic logic [2:0] join_ring(bit wr, ref lock_result_t r);
    int t;
    if (m_fill > 0) begin
      t = (m_tail + SLOTS - 1) % SLOTS;
      if (wr ? (m_is_wr[t] && !m_first[t]) : !m_is_wr[t]) begin
        if (m_wait[t] >= WMAX) return ST_FULL;
        m_wait[t]++;
        r.queued_slot = t;
        return ST_QUEUED;
      end
    end
    if (m_fill >= SLOTS) return ST_FULL;
    t = m_tail;
    m_is_wr[t] = wr;
    m_wait[t] = 1;
    m_first[t] = 0;
    m_tail = (m_tail + 1) % SLOTS;
    m_fill++;
    r.queued_slot = t;
    return ST_QUEUED;
  endfunction

  function automatic lock_result_t predict_lock(logic [2:0] md, logic [3:0] tk);
    lock_result_t r;
    int off;
    r = '0;
    r.status = ST_BAD_TICKET;
    if (md == MODE_READ_WAIT || md == MODE_READ_TRY) begin
      if (m_closed) r.status = ST_CLOSED;
      else begin
        drop_empty();
        if (m_lock != LOCK_WRITER && m_fill == 0) begin
          if (m_readers >= WMAX) r.status = ST_BUSY;
          else begin
            m_readers++;
            m_lock = LOCK_READERS;
            r.status = ST_GRANTED;
          end
        end else if (md == MODE_READ_TRY) r.status = ST_BUSY;
        else r.status = join_ring(0, r);
      end
    end else if (md == MODE_WRITE_WAIT || md == MODE_WRITE_TRY) begin
      if (m_closed) r.status = ST_CLOSED;
      else if (m_lock == LOCK_FREE) begin
        m_lock = LOCK_WRITER;
        r.status = ST_GRANTED;
      end else if (md == MODE_WRITE_TRY) r.status = ST_BUSY;
      else r.status = join_ring(1, r);
    end else if (md == MODE_RELEASE) begin
      if (m_lock == LOCK_WRITER) begin
        m_lock = LOCK_FREE;
        r.status = ST_GRANTED;
        grant_head(r);
      end else if (m_readers > 0) begin
        m_readers--;
        r.status = ST_GRANTED;
        if (m_readers == 0) begin
          m_lock = LOCK_FREE;
          grant_head(r);
        end
      end else r.status = ST_NOT_HELD;
    end else if (md == MODE_CANCEL) begin
      off = (tk + SLOTS - m_head) % SLOTS;
      if (off < m_fill && m_wait[tk] > 0) begin
        m_wait[tk]--;
        r.status = ST_CANCELLED;
      end
    end
    r.lock_mode = m_lock;
    r.readers_holding = m_readers;
    return r;
  endfunction

  always @(posedge clk) begin
    lock_result_t w;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected transaction at cycle %0d", cycles);
      end else begin
        w = pending_results.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (queued_slot !== w.queued_slot) report("queued_slot", queued_slot, w.queued_slot);
        if (lock_mode !== w.lock_mode) report("lock_mode", lock_mode, w.lock_mode);
        if (grant_valid !== w.grant_valid) report("grant_valid", grant_valid, w.grant_valid);
        if (grant_is_writer !== w.grant_is_writer)
          report("grant_is_writer", grant_is_writer, w.grant_is_writer);
        if (grant_slot !== w.grant_slot) report("grant_slot", grant_slot, w.grant_slot);
        if (grant_count !== w.grant_count) report("grant_count", grant_count, w.grant_count);
        if (readers_holding !== w.readers_holding)
          report("readers_holding", readers_holding, w.readers_holding);
      end
    end
  end

  task automatic send_request(logic [2:0] md, logic [3:0] tk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1;
    mode <= md;
    ticket <= tk;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_lock(md, tk));
    start <= 0;
    mode <= 3'($urandom);
    ticket <= 4'($urandom);
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_closed(bit v);
    drain();
    closed_valid <= 1;
    closed_data <= v;
    @(posedge clk);
    while (!closed_ready) @(posedge clk);
    m_closed = v;
    closed_valid <= 0;
  endtask

  // a random ticket from the head up to the tail slot just past the live ring
  function automatic logic [3:0] pick_ticket();
    if ($urandom_range(3) == 0 || m_fill == 0) return 4'(m_head);
    return 4'((m_head + $urandom_range(m_fill)) % SLOTS);
  endfunction

  task automatic test_directed();
    send_request(MODE_RELEASE, 0);
    send_request(MODE_CANCEL, 0);
    send_request(3'd6, 4'hf);
    send_request(3'd7, 4'ha);
    send_request(MODE_READ_TRY, 0);
    send_request(MODE_READ_WAIT, 0);
    send_request(MODE_WRITE_TRY, 0);
    send_request(MODE_WRITE_WAIT, 0);
    send_request(MODE_READ_WAIT, 0);
    send_request(MODE_WRITE_WAIT, 0);
    send_request(MODE_READ_WAIT, 0);
    send_request(MODE_CANCEL, 4'hf);
    send_request(MODE_CANCEL, 2);
    send_request(MODE_CANCEL, 1);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_WRITE_WAIT, 0);
  endtask

  task automatic test_closed();
    write_closed(1);
    send_request(MODE_READ_WAIT, 0);
    send_request(MODE_WRITE_TRY, 0);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_CANCEL, 0);
    write_closed(0);
  endtask

  // fill the ring with alternating packs, then overfill it
  task automatic test_ring_full();
    send_request(MODE_WRITE_WAIT, 0);
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(i[0] ? MODE_WRITE_WAIT : MODE_READ_WAIT, 0);
    for (int i = 0; i < SLOTS + 4; i++) send_request(MODE_RELEASE, 0);
  endtask

  // reader pack grows to its limit, then the held reader count hits it
  task automatic test_reader_limit();
    drain();
    while (m_lock != LOCK_FREE || m_fill != 0) begin
      send_request(MODE_RELEASE, 0);
      drain();
    end
    send_request(MODE_WRITE_WAIT, 0);
    for (int i = 0; i < WMAX + 1; i++) send_request(MODE_READ_WAIT, 0);
    send_request(MODE_RELEASE, 0);
    send_request(MODE_READ_WAIT, 0);
    send_request(MODE_READ_TRY, 0);
    for (int i = 0; i < 4; i++) send_request(MODE_RELEASE, 0);
  endtask

  task automatic test_random(int n, int pct);
    int k;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 25) send_request(MODE_READ_WAIT, 4'($urandom));
      else if (k < 32) send_request(MODE_READ_TRY, 4'($urandom));
      else if (k < 50) send_request(MODE_WRITE_WAIT, 4'($urandom));
      else if (k < 56) send_request(MODE_WRITE_TRY, 4'($urandom));
      else if (k < 84) send_request(MODE_RELEASE, 4'($urandom));
      else if (k < 96) send_request(MODE_CANCEL, pick_ticket());
      else send_request(3'($urandom_range(6, 7)), 4'($urandom));
    end
    idle_pct = 0;
  endtask

  initial begin
    m_closed = 0;
    m_lock = LOCK_FREE;
    m_readers = 0;
    m_head = 0;
    m_tail = 0;
    m_fill = 0;
    foreach (m_wait[i]) begin
      m_wait[i] = 0;
      m_is_wr[i] = 0;
      m_first[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_closed(0);
    test_directed();
    test_closed();
    test_ring_full();
    test_random(55, 0);
    drain();
    test_random(55, 55);
    test_closed();
    test_random(55, 0);
    test_random(55, 35);
    test_reader_limit();
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### sim.f
src/frwl_pkg.sv
src/frwl_datapath.sv
src/frwl_ctrl.sv
src/fifo_reader_writer_lock_arbiter_core.sv
verif/fifo_reader_writer_lock_arbiter_core_tb.sv
